// ----- design/rpc_pkg.sv -----
// ----------------------------------------------------------------------------
// rpc_pkg : shared types and constants
// Payload structs, state encodings and fixed widths used by the rolling
// Pearson correlation unit.
// ----------------------------------------------------------------------------
package rpc_pkg;

  localparam int SAMPLE_BITS    = 16;
  localparam int CFG_LEN_BITS   = 6;
  localparam int RESET_WINDOW   = 30;
  localparam int WINDOW_MAX_DEF = 32;
  localparam int FRAC_BITS      = 14;
  localparam int Q_BITS         = FRAC_BITS + 1;
  localparam int CORR_BITS      = 16;
  localparam int QUEUE_DEPTH    = 2;
  localparam int STEP_BITS      = 5;
  localparam int CFG_ADDR_BITS  = 3;
  localparam int CFG_DATA_BITS  = 32;

  // register index (paddr[2])
  localparam logic REG_WINDOW_LENGTH = 1'b0;

  typedef struct packed {
    logic signed [SAMPLE_BITS-1:0] sample_a;
    logic signed [SAMPLE_BITS-1:0] sample_b;
  } in_item_t;

  typedef struct packed {
    logic signed [CORR_BITS-1:0] correlation;
    logic                        degenerate;
  } out_item_t;

  typedef struct packed {
    logic wr;
    logic full;
  } q_push_t;

  typedef struct packed {
    logic rd;
    logic empty;
  } q_pop_t;

  typedef enum logic [1:0] {
    F_IDLE,
    F_PROD,
    F_UPD
  } front_state_t;

  typedef enum logic [2:0] {
    B_IDLE,
    B_VAR,
    B_WIDE,
    B_INIT,
    B_ROOT,
    B_OUT
  } back_state_t;

endpackage

// ----- design/rpc_queue.sv -----
// ----------------------------------------------------------------------------
// rpc_queue : window snapshot queue
// Small FIFO between the front (window update) and back (correlation math).
// ----------------------------------------------------------------------------
module rpc_queue import rpc_pkg::*; #(
  parameter int DATA_W = 8,
  parameter int DEPTH  = QUEUE_DEPTH
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              wr,
  input  logic [DATA_W-1:0] wdata,
  input  logic              rd,
  output logic [DATA_W-1:0] rdata,
  output logic              full,
  output logic              empty
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [DATA_W-1:0] mem_r [DEPTH];
  logic [PW-1:0]     wp_r, wp_nxt, rp_r, rp_nxt;
  logic [CW-1:0]     cnt_r, cnt_nxt;

  assign full  = (cnt_r == CW'(DEPTH));
  assign empty = (cnt_r == '0);
  assign rdata = mem_r[rp_r];

  always_comb begin
    wp_nxt  = wp_r;
    rp_nxt  = rp_r;
    cnt_nxt = cnt_r;
    if (wr) begin
      wp_nxt = (wp_r == PW'(DEPTH - 1)) ? '0 : wp_r + PW'(1);
    end
    if (rd) begin
      rp_nxt = (rp_r == PW'(DEPTH - 1)) ? '0 : rp_r + PW'(1);
    end
    if (wr && !rd) begin
      cnt_nxt = cnt_r + CW'(1);
    end else if (rd && !wr) begin
      cnt_nxt = cnt_r - CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (wr) begin
      mem_r[wp_r] <= wdata;
    end
  end

endmodule

// ----- design/rpc_front.sv -----
// ----------------------------------------------------------------------------
// rpc_front : window front end
// Accepts sample pairs, keeps the pair ring and running sums, and queues a
// sum snapshot once the window is full.
// ----------------------------------------------------------------------------
module rpc_front import rpc_pkg::*; #(
  parameter int WINDOW_MAX = WINDOW_MAX_DEF,
  localparam int LW   = $clog2(WINDOW_MAX + 1),
  localparam int LG   = $clog2(WINDOW_MAX),
  localparam int SUMW = SAMPLE_BITS + LG,
  localparam int SQW  = 2 * SAMPLE_BITS - 1 + LG,
  localparam int XW   = 2 * SAMPLE_BITS + LG,
  localparam int EW   = LW + 2 * SUMW + 2 * SQW + XW
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          clr,
  input  logic [LW-1:0] len,
  input  logic          in_valid,
  output logic          in_stall,
  input  in_item_t      in_data,
  output q_push_t       q_push,
  input  logic          q_full,
  output logic [EW-1:0] q_data
);

  localparam int S  = SAMPLE_BITS;
  localparam int AW = (LG > 0) ? LG : 1;

  front_state_t state_r, state_nxt;

  logic [2*S-1:0] ring_r [WINDOW_MAX];
  logic [2*S-1:0] rd_r;

  logic signed [S-1:0] a_r, b_r;
  logic [2*S-2:0]      naa_r, nbb_r, oaa_r, obb_r;
  logic signed [2*S-1:0] nab_r, oab_r;
  logic signed [2*S-1:0] taa, tbb, tab, uaa, ubb, uab;
  logic signed [S-1:0] old_a, old_b;

  logic [AW-1:0] slot_r, slot_nxt;
  logic [LW-1:0] fill_r, fill_nxt;
  logic signed [SUMW-1:0] sa_r, sa_nxt, sb_r, sb_nxt;
  logic [SQW-1:0]         saa_r, saa_nxt, sbb_r, sbb_nxt;
  logic signed [XW-1:0]   sab_r, sab_nxt;

  logic accept, full_before, full_after, commit;

  assign accept   = in_valid && (state_r == F_IDLE);
  assign in_stall = (state_r != F_IDLE);
  assign old_a    = rd_r[2*S-1:S];
  assign old_b    = rd_r[S-1:0];

  assign full_before = (fill_r >= len);
  assign full_after  = full_before || ((fill_r + LW'(1)) >= len);
  assign commit      = (state_r == F_UPD) && (!full_after || !q_full);

  assign q_push.wr   = (state_r == F_UPD) && full_after && !q_full;
  assign q_push.full = q_full;
  assign q_data      = {len, sa_nxt, sb_nxt, saa_nxt, sbb_nxt, sab_nxt};

  always_comb begin
    taa = a_r * a_r;
    tbb = b_r * b_r;
    tab = a_r * b_r;
    uaa = old_a * old_a;
    ubb = old_b * old_b;
    uab = old_a * old_b;
  end

  always_comb begin
    sa_nxt  = sa_r + SUMW'(a_r);
    sb_nxt  = sb_r + SUMW'(b_r);
    saa_nxt = saa_r + SQW'(naa_r);
    sbb_nxt = sbb_r + SQW'(nbb_r);
    sab_nxt = sab_r + XW'(nab_r);
    if (full_before) begin
      sa_nxt  = sa_nxt - SUMW'(old_a);
      sb_nxt  = sb_nxt - SUMW'(old_b);
      saa_nxt = saa_nxt - SQW'(oaa_r);
      sbb_nxt = sbb_nxt - SQW'(obb_r);
      sab_nxt = sab_nxt - XW'(oab_r);
    end
    slot_nxt = ((LW'(slot_r) + LW'(1)) == len) ? '0 : slot_r + AW'(1);
    fill_nxt = full_before ? fill_r : fill_r + LW'(1);
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      F_IDLE: if (accept) state_nxt = F_PROD;
      F_PROD: state_nxt = F_UPD;
      F_UPD:  if (commit) state_nxt = F_IDLE;
      default: state_nxt = F_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= F_IDLE;
      slot_r  <= '0;
      fill_r  <= '0;
      sa_r    <= '0;
      sb_r    <= '0;
      saa_r   <= '0;
      sbb_r   <= '0;
      sab_r   <= '0;
    end else begin
      state_r <= state_nxt;
      if (clr) begin
        slot_r <= '0;
        fill_r <= '0;
        sa_r   <= '0;
        sb_r   <= '0;
        saa_r  <= '0;
        sbb_r  <= '0;
        sab_r  <= '0;
      end else if (commit) begin
        slot_r <= slot_nxt;
        fill_r <= fill_nxt;
        sa_r   <= sa_nxt;
        sb_r   <= sb_nxt;
        saa_r  <= saa_nxt;
        sbb_r  <= sbb_nxt;
        sab_r  <= sab_nxt;
      end
    end
  end

  // payload: sample latch, ring, product registers
  always_ff @(posedge clk) begin
    if (accept) begin
      a_r  <= in_data.sample_a;
      b_r  <= in_data.sample_b;
      rd_r <= ring_r[slot_r];
    end
    if (state_r == F_PROD) begin
      naa_r <= taa[2*S-2:0];
      nbb_r <= tbb[2*S-2:0];
      nab_r <= tab;
      oaa_r <= uaa[2*S-2:0];
      obb_r <= ubb[2*S-2:0];
      oab_r <= uab;
    end
    if (commit) begin
      ring_r[slot_r] <= {a_r, b_r};
    end
  end

endmodule

// ----- design/rpc_back.sv -----
// ----------------------------------------------------------------------------
// rpc_back : correlation back end
// Variances and covariance from a sum snapshot, split wide products, then a
// bit-serial root search for the Q1.14 coefficient.
// ----------------------------------------------------------------------------
module rpc_back import rpc_pkg::*; #(
  parameter int WINDOW_MAX = WINDOW_MAX_DEF,
  localparam int LW   = $clog2(WINDOW_MAX + 1),
  localparam int LG   = $clog2(WINDOW_MAX),
  localparam int SUMW = SAMPLE_BITS + LG,
  localparam int SQW  = 2 * SAMPLE_BITS - 1 + LG,
  localparam int XW   = 2 * SAMPLE_BITS + LG,
  localparam int EW   = LW + 2 * SUMW + 2 * SQW + XW
) (
  input  logic          clk,
  input  logic          rst_n,
  input  q_pop_t        q_pop_in,
  output logic          q_rd,
  input  logic [EW-1:0] q_data,
  output logic          out_valid,
  input  logic          out_stall,
  output out_item_t     out_data
);

  localparam int VW = 2 * SAMPLE_BITS - 1 + 2 * LG;   // variance width
  localparam int MW = XW + LW + 1;                    // product width
  localparam int HW = (VW + 1) / 2;                   // half operand
  localparam int PW = 4 * HW;                         // wide product
  localparam int QS = 2 * FRAC_BITS;                  // Q14 squared scale
  localparam int DW = 2 * VW + QS + 2;                // root datapath

  back_state_t state_r, state_nxt;
  logic [STEP_BITS-1:0] step_r;

  logic [LW-1:0]          len_r;
  logic signed [SUMW-1:0] sa_r, sb_r;
  logic [SQW-1:0]         saa_r, sbb_r;
  logic signed [XW-1:0]   sab_r;

  logic signed [XW-1:0]   mx;
  logic signed [SUMW-1:0] my, mz;
  logic signed [MW-1:0]   m1_r, m2_r, diff, ndiff;

  logic [VW-1:0] va_r, vb_r, mag_r;
  logic          neg_r;

  logic [2*HW-1:0] opa, opb;
  logic [HW-1:0]   ah, bh;
  logic [2*HW-1:0] pp_r;
  logic [PW-1:0]   pp_sh;
  logic [PW-1:0]   p_r, r_r;
  logic [2:0]      idx;

  logic [DW-1:0]     d_r, u_r, v_r, w_r;
  logic [Q_BITS-1:0] q_r, q_fin;
  logic              take;
  logic [CORR_BITS-1:0] qx;

  out_item_t out_r;

  assign q_rd      = (state_r == B_IDLE) && !q_pop_in.empty;
  assign out_valid = (state_r == B_OUT);
  assign out_data  = out_r;

  // variance / covariance operand select
  always_comb begin
    case (step_r[2:1])
      2'd0: begin
        mx = XW'(saa_r);
        my = sa_r;
        mz = sa_r;
      end
      2'd1: begin
        mx = XW'(sbb_r);
        my = sb_r;
        mz = sb_r;
      end
      default: begin
        mx = sab_r;
        my = sa_r;
        mz = sb_r;
      end
    endcase
    diff  = m1_r - m2_r;
    ndiff = -diff;
  end

  // split multiplication select
  always_comb begin
    idx = step_r[3:1];
    opa = idx[2] ? (2*HW)'(mag_r) : (2*HW)'(va_r);
    opb = idx[2] ? (2*HW)'(mag_r) : (2*HW)'(vb_r);
    ah  = idx[1] ? opa[2*HW-1:HW] : opa[HW-1:0];
    bh  = idx[0] ? opb[2*HW-1:HW] : opb[HW-1:0];
    case ({idx[1], idx[0]})
      2'b00:   pp_sh = PW'(pp_r);
      2'b11:   pp_sh = PW'(pp_r) << (2 * HW);
      default: pp_sh = PW'(pp_r) << HW;
    endcase
  end

  // root step: accept the trial bit when the remainder covers it
  always_comb begin
    take  = (d_r >= w_r);
    q_fin = {q_r[Q_BITS-2:0], take};
    qx    = CORR_BITS'(q_fin);
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      B_IDLE: if (!q_pop_in.empty) state_nxt = B_VAR;
      B_VAR: begin
        if (step_r == STEP_BITS'(5)) begin
          state_nxt = ((va_r == '0) || (vb_r == '0)) ? B_OUT : B_WIDE;
        end
      end
      B_WIDE: if (step_r == STEP_BITS'(15)) state_nxt = B_INIT;
      B_INIT: state_nxt = B_ROOT;
      B_ROOT: if (step_r == STEP_BITS'(2 * Q_BITS - 1)) state_nxt = B_OUT;
      B_OUT:  if (!out_stall) state_nxt = B_IDLE;
      default: state_nxt = B_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= B_IDLE;
      step_r  <= '0;
    end else begin
      state_r <= state_nxt;
      if (state_nxt != state_r) begin
        step_r <= '0;
      end else begin
        step_r <= step_r + STEP_BITS'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    unique case (state_r)
      B_IDLE: begin
        if (!q_pop_in.empty) begin
          {len_r, sa_r, sb_r, saa_r, sbb_r, sab_r} <= q_data;
        end
      end
      B_VAR: begin
        if (!step_r[0]) begin
          m1_r <= $signed({1'b0, len_r}) * mx;
          m2_r <= my * mz;
        end else begin
          case (step_r[2:1])
            2'd0:    va_r <= diff[VW-1:0];
            2'd1:    vb_r <= diff[VW-1:0];
            default: begin
              neg_r <= diff[MW-1];
              mag_r <= diff[MW-1] ? ndiff[VW-1:0] : diff[VW-1:0];
            end
          endcase
          if (step_r == STEP_BITS'(5)) begin
            out_r.correlation <= '0;
            out_r.degenerate  <= 1'b1;
          end
        end
        p_r <= '0;
        r_r <= '0;
      end
      B_WIDE: begin
        if (!step_r[0]) begin
          pp_r <= ah * bh;
        end else if (idx[2]) begin
          r_r <= r_r + pp_sh;
        end else begin
          p_r <= p_r + pp_sh;
        end
      end
      B_INIT: begin
        d_r <= DW'(r_r) << QS;
        v_r <= DW'(p_r) << QS;
        u_r <= '0;
        q_r <= '0;
      end
      B_ROOT: begin
        if (!step_r[0]) begin
          w_r <= u_r + v_r;
        end else begin
          if (take) begin
            d_r <= d_r - w_r;
            u_r <= (u_r >> 1) + v_r;
          end else begin
            u_r <= u_r >> 1;
          end
          v_r <= v_r >> 2;
          q_r <= q_fin;
          out_r.correlation <= neg_r ? -qx : qx;
          out_r.degenerate  <= 1'b0;
        end
      end
      B_OUT: ;
      default: ;
    endcase
  end

endmodule

// ----- design/rolling_pearson_correlation_unit.sv -----
// ----------------------------------------------------------------------------
// rolling_pearson_correlation_unit : rolling Pearson correlation, top level
// Sliding window of sample pairs; emits the window correlation in Q1.14 once
// the window holds window_length pairs.
// ----------------------------------------------------------------------------
//  channel  dir    handshake                    payload
//  in_      in     in_valid / in_stall          in_item_t  (sample_a, sample_b)
//  out_     out    out_valid / out_stall        out_item_t (correlation, degenerate)
//  cfg_     in     APB psel/penable/pwrite      window_length at byte 0
//
//  Front: one item at a time: ring read, square products, sum update; the
//  update waits while the snapshot queue is full. Back: one result at a
//  time: variances, split wide products, then the 15-bit root search;
//  a degenerate window skips the products and the root search.
//  Reset: synchronous, active low; window_length returns to 30, window empty.
//  A two-entry snapshot queue lets the front keep taking items while the
//  back works or its result sits stalled on the output.
// ----------------------------------------------------------------------------
module rolling_pearson_correlation_unit import rpc_pkg::*; #(
  parameter int WINDOW_MAX = WINDOW_MAX_DEF
) (
  input  logic                     clk,
  input  logic                     rst_n,
  // sample pairs
  input  logic                     in_valid,
  output logic                     in_stall,
  input  in_item_t                 in_data,
  // results
  output logic                     out_valid,
  input  logic                     out_stall,
  output out_item_t                out_data,
  // configuration
  input  logic                     cfg_psel,
  input  logic                     cfg_penable,
  input  logic                     cfg_pwrite,
  input  logic [CFG_ADDR_BITS-1:0] cfg_paddr,
  input  logic [CFG_DATA_BITS-1:0] cfg_pwdata,
  output logic [CFG_DATA_BITS-1:0] cfg_prdata,
  output logic                     cfg_pready
);

  localparam int LW   = $clog2(WINDOW_MAX + 1);
  localparam int LG   = $clog2(WINDOW_MAX);
  localparam int SUMW = SAMPLE_BITS + LG;
  localparam int SQW  = 2 * SAMPLE_BITS - 1 + LG;
  localparam int XW   = 2 * SAMPLE_BITS + LG;
  localparam int EW   = LW + 2 * SUMW + 2 * SQW + XW;

  logic [CFG_LEN_BITS-1:0] wlen_r;
  logic                    cfg_hit;
  logic [LW-1:0]           len_eff;

  q_push_t       q_push;
  q_pop_t        q_pop;
  logic          q_full, q_empty, q_rd;
  logic [EW-1:0] q_wdata, q_rdata;

  // APB: writes land on the access phase; any write to window_length also
  // empties the window in the front end.
  assign cfg_pready = 1'b1;
  assign cfg_hit    = cfg_psel && cfg_penable && cfg_pwrite &&
                      (cfg_paddr[2] == REG_WINDOW_LENGTH);
  assign cfg_prdata = (cfg_paddr[2] == REG_WINDOW_LENGTH) ?
                      CFG_DATA_BITS'(wlen_r) : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wlen_r <= CFG_LEN_BITS'(RESET_WINDOW);
    end else if (cfg_hit) begin
      wlen_r <= cfg_pwdata[CFG_LEN_BITS-1:0];
    end
  end

  // window length clamped to [2, WINDOW_MAX]
  always_comb begin
    if (int'(wlen_r) > WINDOW_MAX) begin
      len_eff = LW'(WINDOW_MAX);
    end else if (int'(wlen_r) < 2) begin
      len_eff = LW'(2);
    end else begin
      len_eff = LW'(wlen_r);
    end
  end

  assign q_pop.rd    = q_rd;
  assign q_pop.empty = q_empty;

  rpc_front #(.WINDOW_MAX(WINDOW_MAX)) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .clr      (cfg_hit),
    .len      (len_eff),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .q_push   (q_push),
    .q_full   (q_full),
    .q_data   (q_wdata)
  );

  rpc_queue #(.DATA_W(EW), .DEPTH(QUEUE_DEPTH)) u_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .wr    (q_push.wr),
    .wdata (q_wdata),
    .rd    (q_pop.rd),
    .rdata (q_rdata),
    .full  (q_full),
    .empty (q_empty)
  );

  rpc_back #(.WINDOW_MAX(WINDOW_MAX)) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_pop_in  (q_pop),
    .q_rd      (q_rd),
    .q_data    (q_rdata),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule

// ----- design/rpc_checker.sv -----
// ----------------------------------------------------------------------------
// rpc_checker : port-level assertions
// Watches the top-level ports of the correlation unit over time.
// ----------------------------------------------------------------------------
module rpc_checker import rpc_pkg::*; (
  input logic                     clk,
  input logic                     rst_n,
  input logic                     in_valid,
  input logic                     in_stall,
  input in_item_t                 in_data,
  input logic                     out_valid,
  input logic                     out_stall,
  input out_item_t                out_data,
  input logic                     cfg_psel,
  input logic                     cfg_penable,
  input logic                     cfg_pwrite,
  input logic [CFG_ADDR_BITS-1:0] cfg_paddr,
  input logic [CFG_DATA_BITS-1:0] cfg_pwdata,
  input logic [CFG_DATA_BITS-1:0] cfg_prdata,
  input logic                     cfg_pready
);

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("result dropped or changed while stalled");

  // reset leaves no result pending
  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

  // front takes one item at a time
  a_front_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("front accepted back-to-back items");

  // config port never waits
  a_pready: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_psel |-> cfg_pready)
    else $error("pready low");

endmodule

bind rolling_pearson_correlation_unit rpc_checker u_rpc_checker (.*);

// ----- tb/tb_top.sv -----
// ----------------------------------------------------------------------------
// tb_top : rolling Pearson correlation unit testbench
// Streams sample pairs through the unit under several window lengths and
// random idling on both channels. A local model tracks the window and its
// sums, predicts each correlation result, and the checker matches every
// result against the oldest pending prediction.
// ----------------------------------------------------------------------------
module tb_top;
  import rpc_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int WIN_MAX     = WINDOW_MAX_DEF;
  localparam int CYCLE_LIMIT = 1000000;
  localparam int SETTLE      = 120;   // idle wait for the back end after the last result

  localparam logic [CFG_ADDR_BITS-1:0] ADDR_WINDOW = 3'd0;
  localparam logic [CFG_ADDR_BITS-1:0] ADDR_NONE   = 3'd4;  // past the register list

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  logic      in_valid = 1'b0;
  logic      in_stall;
  in_item_t  in_data = '0;
  logic      out_valid;
  logic      out_stall = 1'b0;
  out_item_t out_data;

  logic                     cfg_psel = 1'b0;
  logic                     cfg_penable = 1'b0;
  logic                     cfg_pwrite = 1'b0;
  logic [CFG_ADDR_BITS-1:0] cfg_paddr = '0;
  logic [CFG_DATA_BITS-1:0] cfg_pwdata = '0;
  logic [CFG_DATA_BITS-1:0] cfg_prdata;
  logic                     cfg_pready;

  rolling_pearson_correlation_unit u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_data    (in_data),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_data   (out_data),
    .cfg_psel   (cfg_psel),
    .cfg_penable(cfg_penable),
    .cfg_pwrite (cfg_pwrite),
    .cfg_paddr  (cfg_paddr),
    .cfg_pwdata (cfg_pwdata),
    .cfg_prdata (cfg_prdata),
    .cfg_pready (cfg_pready)
  );

  initial begin
    forever #2 clk = ~clk;
  end

  // ---------------------------------------------------------------------------
  // Window model: ring of pairs plus running sums, mirrors the unit's state
  // ---------------------------------------------------------------------------
  logic [5:0]               window_reg;
  logic signed [15:0]       ring_a [WIN_MAX];
  logic signed [15:0]       ring_b [WIN_MAX];
  int unsigned              next_slot;
  int unsigned              filled;
  longint                   sum_a, sum_b, sum_aa, sum_bb, sum_ab;

  out_item_t corr_expect_q [$];
  int        mismatch_count = 0;
  int        cycle_count = 0;

  // receiver control
  int hold_cycles = 0;   // forced stall length, counted down by the stall process
  bit calm = 1'b0;       // no idling on either side while set

  function automatic int unsigned window_eff();
    if (window_reg < 2) return 2;
    if (window_reg > WIN_MAX) return WIN_MAX;
    return window_reg;
  endfunction

  function automatic void empty_window();
    next_slot = 0;
    filled    = 0;
    sum_a = 0; sum_b = 0; sum_aa = 0; sum_bb = 0; sum_ab = 0;
  endfunction

  // Advance the model by one pair; returns 1 with the expected result once
  // the window is full.
  function automatic bit predict_correlation(input logic signed [15:0] a,
                                             input logic signed [15:0] b,
                                             output out_item_t res);
    int unsigned len;
    int unsigned slot;
    longint      va, vb, num, mag;
    logic [63:0] uva, uvb, umag;
    logic [127:0] var_prod, num_sq, lhs;
    int unsigned lo, hi, mid;
    bit          neg;
    len  = window_eff();
    slot = next_slot % len;
    res  = '0;
    if (filled >= len) begin
      sum_a  -= ring_a[slot];
      sum_b  -= ring_b[slot];
      sum_aa -= longint'(ring_a[slot]) * ring_a[slot];
      sum_bb -= longint'(ring_b[slot]) * ring_b[slot];
      sum_ab -= longint'(ring_a[slot]) * ring_b[slot];
    end else begin
      filled++;
    end
    ring_a[slot] = a;
    ring_b[slot] = b;
    sum_a  += a;
    sum_b  += b;
    sum_aa += longint'(a) * a;
    sum_bb += longint'(b) * b;
    sum_ab += longint'(a) * b;
    next_slot = (slot + 1) % len;
    if (filled < len) return 1'b0;

    va = longint'(len) * sum_aa - sum_a * sum_a;
    vb = longint'(len) * sum_bb - sum_b * sum_b;
    if (va == 0 || vb == 0) begin
      res.degenerate = 1'b1;
      return 1'b1;
    end
    num  = longint'(len) * sum_ab - sum_a * sum_b;
    neg  = num < 0;
    mag  = neg ? -num : num;
    uva  = va;
    uvb  = vb;
    umag = mag;
    var_prod = {64'd0, uva} * {64'd0, uvb};
    num_sq   = ({64'd0, umag} * {64'd0, umag}) << 28;
    // largest q in [0, 1.0] with q^2 * Va * Vb <= N^2 * 2^28
    lo = 0;
    hi = 16384;
    while (lo < hi) begin
      mid = (lo + hi + 1) / 2;
      lhs = var_prod * {96'd0, 32'(mid * mid)};
      if (lhs <= num_sq) lo = mid;
      else hi = mid - 1;
    end
    res.correlation = neg ? -16'(lo) : 16'(lo);
    return 1'b1;
  endfunction

  // ---------------------------------------------------------------------------
  // Result checker: every accepted result against the oldest prediction
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (corr_expect_q.size() == 0) begin
        $display("%0t: unexpected result corr=%0d degenerate=%0b", $time,
                 out_data.correlation, out_data.degenerate);
        mismatch_count++;
      end else begin
        out_item_t want;
        want = corr_expect_q.pop_front();
        if (out_data.correlation !== want.correlation) begin
          $display("%0t: correlation expected %0d actual %0d", $time,
                   want.correlation, out_data.correlation);
          mismatch_count++;
        end
        if (out_data.degenerate !== want.degenerate) begin
          $display("%0t: degenerate expected %0b actual %0b", $time,
                   want.degenerate, out_data.degenerate);
          mismatch_count++;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Receiver stall: forced hold-offs first, none while calm, then short random
  // stalls with an occasional long one.
  // ---------------------------------------------------------------------------
  int stall_run = 0;
  always @(posedge clk) begin
    if (hold_cycles > 0) begin
      out_stall   <= 1'b1;
      hold_cycles <= hold_cycles - 1;
    end else if (calm) begin
      out_stall <= 1'b0;
    end else if (stall_run > 0) begin
      out_stall <= 1'b1;
      stall_run <= stall_run - 1;
    end else begin
      int unsigned r;
      r = $urandom_range(0, 99);
      if (r < 60)      out_stall <= 1'b0;
      else if (r < 97) out_stall <= 1'b1;
      else begin
        out_stall <= 1'b1;
        stall_run <= $urandom_range(20, 120);
      end
    end
  end

  // run limit
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("** rolling_pearson_correlation_unit: FAILED **");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Sender and configuration tasks
  // ---------------------------------------------------------------------------
  function automatic int unsigned gap_len();
    int unsigned r;
    if (calm) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 93) return $urandom_range(1, 3);
    return $urandom_range(10, 60);
  endfunction

  // Offer one pair, wait for acceptance, then predict.
  task automatic send_pair(input logic signed [15:0] a, input logic signed [15:0] b);
    int unsigned gap;
    out_item_t   res;
    gap = gap_len();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid          <= 1'b1;
    in_data.sample_a  <= a;
    in_data.sample_b  <= b;
    do @(posedge clk); while (in_stall);
    if (predict_correlation(a, b, res)) corr_expect_q = {corr_expect_q, res};
  endtask

  task automatic go_quiet_input();
    in_valid <= 1'b0;
    @(posedge clk);
  endtask

  // Wait for every prediction to be met, then let the back end settle.
  task automatic drain();
    go_quiet_input();
    while (corr_expect_q.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic cfg_write(input logic [CFG_ADDR_BITS-1:0] addr, input logic [5:0] value);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= addr;
    cfg_pwdata  <= {26'd0, value} | (32'($urandom) & 32'hFFFF_FFC0);
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    if (addr == ADDR_WINDOW) begin
      window_reg = value;
      empty_window();
    end
    @(posedge clk);
  endtask

  task automatic cfg_check_read();
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    cfg_paddr   <= ADDR_WINDOW;
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    if (cfg_prdata[5:0] !== window_reg) begin
      $display("%0t: window_length read expected %0d actual %0d", $time,
               window_reg, cfg_prdata[5:0]);
      mismatch_count++;
    end
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    @(posedge clk);
  endtask

  task automatic set_window(input logic [5:0] value);
    cfg_write(ADDR_WINDOW, value);
    cfg_check_read();
  endtask

  // Random sample pair: extremes, small values, full range, near-correlated or tied series.
  task automatic random_pair(output logic signed [15:0] a, output logic signed [15:0] b);
    int unsigned kind;
    kind = $urandom_range(0, 9);
    a = 16'($urandom);
    b = 16'($urandom);
    case (kind)
      0: begin
        a = $urandom_range(0, 1) ? 16'sh7FFF : 16'sh8000;
        b = $urandom_range(0, 1) ? 16'sh7FFF : 16'sh8000;
      end
      1: begin
        a = 16'($signed($urandom_range(0, 16)) - 8);
        b = 16'($signed($urandom_range(0, 16)) - 8);
      end
      2, 3: b = a + 16'($signed($urandom_range(0, 64)) - 32);
      4:    b = -a + 16'($signed($urandom_range(0, 64)) - 32);
      5:    b = a;
      default: ;
    endcase
  endtask

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------
  task automatic test_register_access();
    cfg_check_read();                    // reset value 30
    cfg_write(ADDR_NONE, 6'd5);          // beyond the register list: ignored
    cfg_check_read();
  endtask

  task automatic test_directed();
    set_window(6'd0);                    // below range, acts as 2
    send_pair(16'sh7FFF, 16'sh7FFF);
    send_pair(16'sh8000, 16'sh8000);     // +1.0
    send_pair(16'sh7FFF, 16'sh8000);     // second series flat
    send_pair(16'sh7FFF, 16'sh8000);     // both series flat
    send_pair(16'sh0000, 16'sh1234);     // -1.0
    send_pair(16'sh0000, 16'sh1234);     // flat
    send_pair(16'sh0005, 16'shFFFF);
    send_pair(16'sh0005, 16'sh0000);     // first series flat only
    drain();
    set_window(6'd1);                    // also acts as 2
    send_pair(16'sh5555, 16'shAAAA);
    send_pair(16'shAAAA, 16'sh5555);
    send_pair(16'shFFFF, 16'sh0001);
    drain();
    set_window(6'd3);
    send_pair(16'sh0001, 16'sh0003);
    send_pair(16'sh0002, 16'sh0001);
    send_pair(16'sh0003, 16'sh0002);     // partial correlation
    send_pair(16'sh8000, 16'sh7FFF);
    send_pair(16'sh7FFF, 16'sh8000);
    send_pair(16'sh0000, 16'sh0000);
    drain();
  endtask

  task automatic test_random_windows();
    logic [5:0] settings [10];
    int unsigned count;
    logic signed [15:0] a, b;
    settings = '{6'd2, 6'd32, 6'd63, 6'd4, 6'd2, 6'd33, 6'd7, 6'd3, 6'd5, 6'd2};
    for (int p = 0; p < 14; p++) begin
      if (p < 10) set_window(settings[p]);
      else set_window(6'($urandom_range(0, 63)));
      calm  = (p == 4);
      count = (window_eff() > 8) ? 70 : 40;
      for (int i = 0; i < count; i++) begin
        if ($urandom_range(0, 19) == 0) begin
          // flat stretch in the first series: zero variance in windows of four or fewer
          for (int k = 0; k < 4; k++) send_pair(16'sh0100, 16'($urandom));
        end else begin
          random_pair(a, b);
          send_pair(a, b);
        end
      end
      drain();
      calm = 1'b0;
      // stray write past the list must leave the window intact
      if (p % 3 == 0) cfg_write(ADDR_NONE, 6'($urandom));
    end
  endtask

  task automatic test_backpressure();
    logic signed [15:0] a, b;
    set_window(6'd2);
    calm        = 1'b1;
    hold_cycles = 600;                   // queue and front fill, input stalls
    for (int i = 0; i < 40; i++) begin
      random_pair(a, b);
      send_pair(a, b);
    end
    calm = 1'b0;
    drain();                             // sender waits for every result
    for (int i = 0; i < 20; i++) begin
      random_pair(a, b);
      send_pair(a, b);
    end
    drain();
  endtask

  initial begin
    window_reg = 6'(RESET_WINDOW);
    empty_window();
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_register_access();
    test_directed();
    test_random_windows();
    test_backpressure();
    if (mismatch_count == 0) begin
      $display("** rolling_pearson_correlation_unit: PASSED **");
    end else begin
      $display("** rolling_pearson_correlation_unit: FAILED **");
    end
    $finish;
  end

endmodule
